>>> hw/rtl/isort_pkg.sv
// Shared types and constants for the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

	localparam int DATA_WIDTH = 32;

	// One input transfer: value plus end-of-run mark.
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         last;
	} in_item_t;

	// One result transfer.
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] sorted_value;
		logic                         last_res;
		logic                         overflow;
	} res_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture input item, start position at count
		logic drop;     // buffer full: discard value, flag overflow
		logic rd;       // read entry below the current position
		logic shift;    // move the entry read up one place
		logic place;    // write the new value at the current position
		logic out_rd;   // read next entry for output
		logic out_end;  // final output read: clear run state
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;       // buffer holds its capacity
		logic pos_zero;   // position at bottom of buffer
		logic pos_one;    // position one above bottom
		logic greater;    // entry read is greater than new value
		logic out_final;  // output index at last buffered entry
		logic last;       // captured item ends the run
	} ctrl_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/isort_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module isort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/isort_ctrl.sv
// Controller state machine for the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none

module isort_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire isort_pkg::ctrl_sts_t   sts,
	output isort_pkg::ctrl_cmd_t        cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CMP,
		ST_PLACE,
		ST_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (sts.full) begin
					cmd.drop = 1'b1;
					state_d  = sts.last ? ST_OUT : ST_IDLE;
				end else if (sts.pos_zero) begin
					cmd.place = 1'b1;
					state_d   = sts.last ? ST_OUT : ST_IDLE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (sts.greater) begin
					cmd.shift = 1'b1;
					state_d   = sts.pos_one ? ST_PLACE : ST_CMP;
				end else begin
					cmd.place = 1'b1;
					state_d   = sts.last ? ST_OUT : ST_IDLE;
				end
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d   = sts.last ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				cmd.out_rd = 1'b1;
				if (sts.out_final) begin
					cmd.out_end = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and the registered busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

>>> hw/rtl/isort_dp.sv
// Datapath for the insertion sorter: buffer RAM, counters and result stage.
`timescale 1ns / 1ps
`default_nettype none

module isort_dp #(
	parameter int MAX_ITEMS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire isort_pkg::in_item_t  item,
	input  wire isort_pkg::ctrl_cmd_t cmd,
	output isort_pkg::ctrl_sts_t      sts,
	output logic                      strobe,
	output isort_pkg::res_item_t      result
);

	localparam int DW = isort_pkg::DATA_WIDTH;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam logic [CW-1:0] ONE  = CW'(1);
	localparam logic [CW-1:0] TWO  = CW'(2);
	localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

	logic signed [DW-1:0] value_q;
	logic                 last_q;
	logic [CW-1:0]        pos_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        k_q;
	logic                 ovf_q;

	logic                 rv_s1;
	logic                 rlast_s1;
	logic                 rovf_s1;

	logic                 strobe_q;
	isort_pkg::res_item_t res_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [DW-1:0]        ram_wdata;
	logic                 ram_re;
	logic [CW-1:0]        raddr_full;
	logic [DW-1:0]        ram_rdata;

	// Buffer write: shifted entry or new value at the current position
	assign ram_we    = cmd.shift | cmd.place;
	assign ram_waddr = pos_q[AW-1:0];
	assign ram_wdata = cmd.shift ? ram_rdata : value_q;

	// Buffer read: output index, or the entry below the next position
	assign ram_re = cmd.rd | cmd.shift | cmd.out_rd;
	always_comb begin
		priority if (cmd.out_rd) begin
			raddr_full = k_q;
		end else if (cmd.shift) begin
			raddr_full = pos_q - TWO;
		end else begin
			raddr_full = pos_q - ONE;
		end
	end

	isort_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(raddr_full[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Status back to the controller
	assign sts.full      = (count_q == FULL);
	assign sts.pos_zero  = (pos_q == '0);
	assign sts.pos_one   = (pos_q == ONE);
	assign sts.greater   = ($signed(ram_rdata) > value_q);
	assign sts.out_final = (k_q == (count_q - ONE));
	assign sts.last      = last_q;

	// Capture the input item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= item.value;
		end
	end

	// Run state: position, count, output index, overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			pos_q   <= '0;
			count_q <= '0;
			k_q     <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_q <= item.last;
				pos_q  <= count_q;
			end
			if (cmd.shift) begin
				pos_q <= pos_q - ONE;
			end
			if (cmd.drop) begin
				ovf_q <= 1'b1;
			end
			if (cmd.place) begin
				count_q <= count_q + ONE;
			end
			if (cmd.out_rd) begin
				k_q <= k_q + ONE;
			end
			if (cmd.out_end) begin
				count_q <= '0;
				k_q     <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// Track output reads through the RAM latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1    <= 1'b0;
			rlast_s1 <= 1'b0;
			rovf_s1  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			rv_s1    <= cmd.out_rd;
			rlast_s1 <= cmd.out_end;
			rovf_s1  <= ovf_q;
			strobe_q <= rv_s1;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (rv_s1) begin
			res_q.sorted_value <= $signed(ram_rdata);
			res_q.last_res     <= rlast_s1;
			res_q.overflow     <= rovf_s1;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/insertion_sorter.sv
// Insertion sorter top level: one item per start transfer, sorted run on last.
// busy covers the check of each item and, unless the buffer was empty or the value is
// dropped, one move per larger entry, then placing it; start is taken when busy is low.
// On last, busy stays high through read-out and N results follow on consecutive
// strobes via the RAM read and result registers; the receiver cannot stall them.
// Reset clears count, overflow and control; buffer contents stay unknown.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter #(
	parameter int MAX_ITEMS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire isort_pkg::in_item_t  item,
	output logic                      strobe,
	output isort_pkg::res_item_t      result
);

	isort_pkg::ctrl_cmd_t cmd;
	isort_pkg::ctrl_sts_t sts;
	logic                 busy_int;

	isort_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy_int),
		.sts   (sts),
		.cmd   (cmd)
	);

	isort_dp #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.sts   (sts),
		.strobe(strobe),
		.result(result)
	);

	assign busy = busy_int;

endmodule

`default_nettype wire

>>> tb/tb_insertion_sorter.sv
// Self-checking testbench for the insertion sorter: directed table, then random runs.
`timescale 1ns / 1ps

module tb_insertion_sorter;

	import isort_pkg::*;

	localparam int MAX_ITEMS   = 16;
	localparam int INSERT_MAX  = MAX_ITEMS + 3;
	localparam int SETTLE_WAIT = 2 * INSERT_MAX + 8;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = 32'sh80000000;

	// One row of the directed table; want is used only where typed in.
	typedef struct {
		in_item_t  it;
		bit        has_want;
		res_item_t want;
	} stim_row_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	in_item_t  item   = '0;
	logic      busy;
	logic      strobe;
	res_item_t result;

	// Predictor state
	logic signed [DATA_WIDTH-1:0] sort_buf [MAX_ITEMS];
	int unsigned                  run_len;
	bit                           run_dropped;
	res_item_t                    run_out [$];

	res_item_t pending_sorted [$];
	stim_row_t dir_rows [$];

	int mismatches      = 0;
	int items_sent      = 0;
	int runs_done       = 0;
	int runs_overflowed = 0;
	int results_seen    = 0;
	int cycles          = 0;

	insertion_sorter #(
		.MAX_ITEMS(MAX_ITEMS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending",
				cycles, pending_sorted.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Insert one value into the model buffer, or drop it when full; on last, emit the sorted run into run_out.
	task automatic sort_predict(input in_item_t it);
		int unsigned pos;
		run_out.delete();
		if (run_len >= MAX_ITEMS) begin
			run_dropped = 1'b1;
		end else begin
			pos = run_len;
			while (pos > 0 && sort_buf[pos-1] > it.value) begin
				sort_buf[pos] = sort_buf[pos-1];
				pos--;
			end
			sort_buf[pos] = it.value;
			run_len++;
		end
		if (it.last) begin
			for (int unsigned k = 0; k < run_len; k++) begin
				run_out.push_back('{sorted_value: sort_buf[k],
					last_res: (k + 1 == run_len), overflow: run_dropped});
			end
			runs_done++;
			if (run_dropped)
				runs_overflowed++;
			run_len     = 0;
			run_dropped = 1'b0;
		end
	endtask

	// Drive one item after a random gap, hold until the transfer, then record the outcome.
	task automatic send_item(input in_item_t it, input int idle_pct,
		input bit has_want, input res_item_t want);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
			if ($urandom_range(39) == 0)
				repeat ($urandom_range(5, 30)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		items_sent++;
		sort_predict(it);
		if (has_want && it.last)
			pending_sorted.push_back(want);
		else
			foreach (run_out[k])
				pending_sorted.push_back(run_out[k]);
	endtask

	// Stop sending until every expected result has arrived and the block has settled.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	function automatic stim_row_t mk_row(input logic [DATA_WIDTH-1:0] v, input bit l,
		input bit has_want = 1'b0, input bit want_last = 1'b0, input bit want_ovf = 1'b0);
		stim_row_t r;
		r.it.value            = v;
		r.it.last             = l;
		r.has_want            = has_want;
		r.want.sorted_value   = v;
		r.want.last_res       = want_last;
		r.want.overflow       = want_ovf;
		return r;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] pick_value(input int mode);
		logic signed [DATA_WIDTH-1:0] v;
		case (mode)
			0: v = $urandom();
			1: v = $signed($urandom_range(8)) - 4;
			default: begin
				case ($urandom_range(6))
					0: v = VAL_MAX;
					1: v = VAL_MIN;
					2: v = 0;
					3: v = -1;
					4: v = VAL_MAX - 1;
					5: v = VAL_MIN + 1;
					default: v = $urandom();
				endcase
			end
		endcase
		return v;
	endfunction

	// One random run: mostly within capacity, some past it to force drops.
	task automatic send_random_run(input int idle_pct);
		int       len;
		int       mode;
		int       r;
		in_item_t it;
		r = $urandom_range(99);
		if (r < 12)
			len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
		else if (r < 25)
			len = 1;
		else
			len = $urandom_range(2, MAX_ITEMS);
		mode = $urandom_range(2);
		for (int i = 0; i < len; i++) begin
			it.value = pick_value(mode);
			it.last  = (i == len - 1);
			send_item(it, idle_pct, 1'b0, '0);
		end
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		res_item_t exp_res;
		if (arst_n && strobe) begin
			results_seen++;
			if (pending_sorted.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d last %0b ovf %0b",
					result.sorted_value, result.last_res, result.overflow));
			end else begin
				exp_res = pending_sorted.pop_front();
				if (result.sorted_value !== exp_res.sorted_value)
					report_mismatch($sformatf("sorted_value %0d, expected %0d",
						result.sorted_value, exp_res.sorted_value));
				if (result.last_res !== exp_res.last_res)
					report_mismatch($sformatf("last_res %b, expected %b (value %0d)",
						result.last_res, exp_res.last_res, exp_res.sorted_value));
				if (result.overflow !== exp_res.overflow)
					report_mismatch($sformatf("overflow %b, expected %b (value %0d)",
						result.overflow, exp_res.overflow, exp_res.sorted_value));
			end
		end
	end

	initial begin
		int phase_pct [3];
		int target;

		phase_pct = '{26, 71, 0};
		run_len     = 0;
		run_dropped = 1'b0;
		foreach (sort_buf[k])
			sort_buf[k] = '0;

		// Single-item runs at the extremes: the output is the value itself
		dir_rows.push_back(mk_row(VAL_MAX, 1'b1, 1'b1, 1'b1, 1'b0));
		dir_rows.push_back(mk_row(VAL_MIN, 1'b1, 1'b1, 1'b1, 1'b0));
		dir_rows.push_back(mk_row(32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0));
		dir_rows.push_back(mk_row(32'hffff_ffff, 1'b1, 1'b1, 1'b1, 1'b0));
		// Full descending run ending in a duplicate: all other insertions move all entries, then a
		// dropped plain item and a dropped final item
		dir_rows.push_back(mk_row(32'h7fff_ffff, 1'b0));
		dir_rows.push_back(mk_row(32'h7fff_fffe, 1'b0));
		dir_rows.push_back(mk_row(32'h4000_0000, 1'b0));
		dir_rows.push_back(mk_row(32'h0001_0000, 1'b0));
		dir_rows.push_back(mk_row(32'h0000_0100, 1'b0));
		dir_rows.push_back(mk_row(32'h0000_0001, 1'b0));
		dir_rows.push_back(mk_row(32'h0000_0000, 1'b0));
		dir_rows.push_back(mk_row(32'hffff_ffff, 1'b0));
		dir_rows.push_back(mk_row(32'hffff_fffe, 1'b0));
		dir_rows.push_back(mk_row(32'hffff_ff00, 1'b0));
		dir_rows.push_back(mk_row(32'hffff_0000, 1'b0));
		dir_rows.push_back(mk_row(32'hc000_0000, 1'b0));
		dir_rows.push_back(mk_row(32'h8000_0002, 1'b0));
		dir_rows.push_back(mk_row(32'h8000_0001, 1'b0));
		dir_rows.push_back(mk_row(32'h8000_0000, 1'b0));
		dir_rows.push_back(mk_row(32'h8000_0000, 1'b0));
		dir_rows.push_back(mk_row(32'h1234_5678, 1'b0));
		dir_rows.push_back(mk_row(32'h0000_0000, 1'b1));
		// Fresh run after the clear, with duplicates
		dir_rows.push_back(mk_row(32'h0000_0005, 1'b0));
		dir_rows.push_back(mk_row(32'h8000_0000, 1'b0));
		dir_rows.push_back(mk_row(32'h0000_0005, 1'b1));

		// Reset
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_rows[i])
			send_item(dir_rows[i].it, 0, dir_rows[i].has_want, dir_rows[i].want);
		drain_results();

		// Random runs in three idling phases, fully drained between phases
		target = items_sent;
		foreach (phase_pct[p]) begin
			target += 110;
			while (items_sent < target)
				send_random_run(phase_pct[p]);
			drain_results();
		end

		$display("Covered %0d items in %0d runs (%0d with dropped values), %0d results checked",
			items_sent, runs_done, runs_overflowed, results_seen);
		$display("Sender gap rates 26, 71 and 0 percent, with full drains between phases");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/isort_pkg.sv
hw/rtl/isort_ram.sv
hw/rtl/isort_ctrl.sv
hw/rtl/isort_dp.sv
hw/rtl/insertion_sorter.sv
tb/tb_insertion_sorter.sv
